// ----- src/lfpd_pkg.sv -----
`default_nettype none
package lfpd_pkg;

	localparam int unsigned DRIVE_LIMIT_DEF = 90;
	localparam int unsigned GAP_BITS_DEF    = 12;

	localparam int unsigned GAIN_W   = 8;
	localparam int unsigned DRIVE_W  = 7;
	localparam int unsigned LINE_W   = 6;
	localparam int unsigned STEP_W   = 8;
	localparam int unsigned TRAVEL_W = 16;
	localparam int unsigned LERR_W   = 5;
	localparam int unsigned STEER_W  = 15;
	localparam int unsigned OUT_W    = 8;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned CROSS_LOW_MM  = 200;
	localparam int unsigned CROSS_HIGH_MM = 400;

	localparam int unsigned LINE_P_RST     = 50;
	localparam int unsigned LINE_D_RST     = 10;
	localparam int unsigned GAP_P_RST      = 38;
	localparam int unsigned GAP_D_RST      = 102;
	localparam int unsigned TARGET_GAP_RST = 200;
	localparam int unsigned FAR_GAP_RST    = 450;
	localparam int unsigned CRUISE_RST     = 27;
	localparam int unsigned GAP_LIMIT_RST  = 50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_GAIN_P   = 3'd0,
		CFG_LINE_GAIN_D   = 3'd1,
		CFG_GAP_GAIN_P    = 3'd2,
		CFG_GAP_GAIN_D    = 3'd3,
		CFG_TARGET_GAP    = 3'd4,
		CFG_FAR_GAP       = 3'd5,
		CFG_CRUISE_DRIVE  = 3'd6,
		CFG_GAP_OUT_LIMIT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_d;
	} line_cfg_t;

	typedef struct packed {
		logic signed [STEER_W-1:0] steer;
		logic                      crossing;
	} line_res_t;

endpackage
`default_nettype wire

// ----- src/lfpd_line_unit.sv -----
`default_nettype none
module lfpd_line_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic [lfpd_pkg::LINE_W-1:0]         line_bits,
	input  wire logic [lfpd_pkg::STEP_W-1:0]         travel_step_mm,
	input  wire lfpd_pkg::line_cfg_t                 cfg,
	output lfpd_pkg::line_res_t                      res
);

	localparam int unsigned TW = lfpd_pkg::TRAVEL_W;
	localparam int unsigned EW = lfpd_pkg::LERR_W;
	localparam int unsigned SW = lfpd_pkg::STEER_W;

	logic signed [EW-1:0] prev_err_q;
	logic [TW-1:0]        travel_q;
	logic                 flag_q;

	logic signed [EW-1:0] pos_raw;
	logic signed [EW-1:0] pos;
	logic signed [EW-1:0] err;
	logic signed [EW:0]   diff;
	logic [TW:0]          travel_sum;
	logic [TW-1:0]        travel_d;
	logic                 flag_d;
	logic                 mark;
	logic signed [SW-1:0] p_term;
	logic signed [SW-1:0] d_term;

	always_comb begin
		pos_raw = '0;
		if (line_bits[0]) pos_raw = pos_raw + 5'sd6;
		if (line_bits[1]) pos_raw = pos_raw + 5'sd4;
		if (line_bits[2]) pos_raw = pos_raw + 5'sd2;
		if (line_bits[3]) pos_raw = pos_raw - 5'sd2;
		if (line_bits[4]) pos_raw = pos_raw - 5'sd4;
		if (line_bits[5]) pos_raw = pos_raw - 5'sd6;
	end

	assign travel_sum = {1'b0, travel_q} + (TW+1)'(travel_step_mm);
	assign mark = line_bits[2] && line_bits[3] && (line_bits[4] || line_bits[1]);

	always_comb begin
		travel_d = travel_sum[TW] ? '1 : travel_sum[TW-1:0];
		flag_d   = flag_q;
		pos      = pos_raw;
		if (mark) begin
			flag_d   = 1'b1;
			travel_d = '0;
			pos      = '0;
		end
		if (flag_d && travel_d > TW'(lfpd_pkg::CROSS_LOW_MM)
				&& travel_d < TW'(lfpd_pkg::CROSS_HIGH_MM)) begin
			pos = '0;
		end
		if (travel_d > TW'(lfpd_pkg::CROSS_HIGH_MM)) begin
			flag_d = 1'b0;
		end
	end

	assign err    = -pos;
	assign diff   = $signed({err[EW-1], err}) - $signed({prev_err_q[EW-1], prev_err_q});
	assign p_term = $signed({1'b0, cfg.gain_p}) * err;
	assign d_term = $signed({1'b0, cfg.gain_d}) * diff;

	assign res.steer    = p_term + d_term;
	assign res.crossing = flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			travel_q   <= '0;
			flag_q     <= 1'b0;
		end else if (en) begin
			prev_err_q <= err;
			travel_q   <= travel_d;
			flag_q     <= flag_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/lfpd_gap_unit.sv -----
`default_nettype none
module lfpd_gap_unit #(
	parameter int unsigned GAP_BITS = lfpd_pkg::GAP_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic [GAP_BITS-1:0]                 gap_distance,
	input  wire logic [GAP_BITS-1:0]                 target_gap,
	input  wire logic [lfpd_pkg::GAIN_W-1:0]         gain_p,
	input  wire logic [lfpd_pkg::GAIN_W-1:0]         gain_d,
	input  wire logic [lfpd_pkg::DRIVE_W-1:0]        limit,
	output logic signed [lfpd_pkg::OUT_W-1:0]        gap_term
);

	localparam int unsigned SW  = GAP_BITS + 12;
	localparam int unsigned SHW = SW - 8;

	logic signed [GAP_BITS:0]   prev_err_q;
	logic signed [GAP_BITS:0]   err;
	logic signed [GAP_BITS+1:0] diff;
	logic signed [SW-1:0]       p_term;
	logic signed [SW-1:0]       d_term;
	logic signed [SW-1:0]       sum;
	logic signed [SHW-1:0]      shifted;
	logic signed [SHW-1:0]      lim;
	logic signed [SHW-1:0]      clamped;

	assign err     = $signed({1'b0, target_gap}) - $signed({1'b0, gap_distance});
	assign diff    = $signed({err[GAP_BITS], err}) - $signed({prev_err_q[GAP_BITS], prev_err_q});
	assign p_term  = $signed({1'b0, gain_p}) * err;
	assign d_term  = $signed({1'b0, gain_d}) * diff;
	assign sum     = p_term + d_term;
	assign shifted = sum[SW-1:8];
	assign lim     = $signed({{(SHW-lfpd_pkg::DRIVE_W){1'b0}}, limit});

	always_comb begin
		if (shifted >= lim) begin
			clamped = lim;
		end else if (shifted <= -lim) begin
			clamped = -lim;
		end else begin
			clamped = shifted;
		end
	end

	assign gap_term = clamped[lfpd_pkg::OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (en) begin
			prev_err_q <= err;
		end
	end

endmodule
`default_nettype wire

// ----- src/lfpd_mixer.sv -----
`default_nettype none
module lfpd_mixer #(
	parameter int unsigned GAP_BITS    = lfpd_pkg::GAP_BITS_DEF,
	parameter int unsigned DRIVE_LIMIT = lfpd_pkg::DRIVE_LIMIT_DEF
) (
	input  wire logic [GAP_BITS-1:0]                 gap_distance,
	input  wire logic [GAP_BITS-1:0]                 far_gap,
	input  wire logic [lfpd_pkg::DRIVE_W-1:0]        cruise_drive,
	input  wire logic signed [lfpd_pkg::OUT_W-1:0]   gap_term,
	input  wire logic signed [lfpd_pkg::STEER_W-1:0] steer,
	output logic signed [lfpd_pkg::OUT_W-1:0]        left_drive,
	output logic signed [lfpd_pkg::OUT_W-1:0]        right_drive
);

	localparam int unsigned MW = lfpd_pkg::STEER_W + 2;
	localparam logic signed [MW-1:0] LIM = MW'(DRIVE_LIMIT);

	logic signed [lfpd_pkg::OUT_W:0] base;
	logic signed [MW-1:0]            left_sum;
	logic signed [MW-1:0]            right_sum;
	logic signed [MW-1:0]            left_clamped;
	logic signed [MW-1:0]            right_clamped;

	always_comb begin
		if (gap_distance > far_gap) begin
			base = $signed({2'b00, cruise_drive});
		end else begin
			base = -$signed({gap_term[lfpd_pkg::OUT_W-1], gap_term});
		end
	end

	assign left_sum  = base + steer;
	assign right_sum = base - steer;

	always_comb begin
		if (left_sum >= LIM) begin
			left_clamped = LIM;
		end else if (left_sum <= -LIM) begin
			left_clamped = -LIM;
		end else begin
			left_clamped = left_sum;
		end
		if (right_sum >= LIM) begin
			right_clamped = LIM;
		end else if (right_sum <= -LIM) begin
			right_clamped = -LIM;
		end else begin
			right_clamped = right_sum;
		end
	end

	assign left_drive  = left_clamped[lfpd_pkg::OUT_W-1:0];
	assign right_drive = right_clamped[lfpd_pkg::OUT_W-1:0];

endmodule
`default_nettype wire

// ----- src/line_follow_pd_drive_mixer_unit.sv -----
// Line-following PD drive mixer with gap keeping, one control tick per transaction.
// Input stream s_*: s_tdata carries line_bits, gap_distance and travel_step_mm.
// Output stream m_*: m_tdata carries left_drive, right_drive and crossing_active.
// Config channel cfg_*: cfg_index selects one of eight registers, cfg_data is the
// value; cfg_ready is always high, write only while no tick is in flight.
// An accepted tick passes the input register, then the output register, to m_tvalid.
// Throughput: one tick per cycle while m_tready is high; the input register feeds
// one combinational pass (sensor weighting, crossing window, line PD, gap PD with
// Q8 gains, mixing, clamping) into the output register with the loop state update.
// When the receiver stalls, the output register holds its result and the input
// register still takes one more tick; s_tready falls only when both are full.
// Reset (arst_n low) clears valid flags, previous errors, travel count and the
// crossing flag, and loads the default register values.
`default_nettype none
module line_follow_pd_drive_mixer_unit #(
	parameter int unsigned DRIVE_LIMIT = lfpd_pkg::DRIVE_LIMIT_DEF,
	parameter int unsigned GAP_BITS    = lfpd_pkg::GAP_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// line_bits[5:0], gap_distance, travel_step_mm, zero fill
	input  wire logic [((lfpd_pkg::LINE_W+GAP_BITS+lfpd_pkg::STEP_W+7)/8)*8-1:0] s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// left_drive[7:0], right_drive[15:8], crossing_active[16], zero fill
	output logic [lfpd_pkg::M_DATA_W-1:0]           m_tdata,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [GAP_BITS-1:0]                cfg_data
);

	localparam int unsigned LW = lfpd_pkg::LINE_W;
	localparam int unsigned PW = lfpd_pkg::STEP_W;
	localparam int unsigned GW = lfpd_pkg::GAIN_W;
	localparam int unsigned DW = lfpd_pkg::DRIVE_W;
	localparam int unsigned OW = lfpd_pkg::OUT_W;

	logic [GW-1:0]       line_p_q;
	logic [GW-1:0]       line_d_q;
	logic [GW-1:0]       gap_p_q;
	logic [GW-1:0]       gap_d_q;
	logic [GAP_BITS-1:0] target_gap_q;
	logic [GAP_BITS-1:0] far_gap_q;
	logic [DW-1:0]       cruise_q;
	logic [DW-1:0]       gap_limit_q;

	logic                valid_s1;
	logic [LW-1:0]       line_bits_s1;
	logic [GAP_BITS-1:0] gap_s1;
	logic [PW-1:0]       step_s1;

	logic                valid_s2;
	logic signed [OW-1:0] left_s2;
	logic signed [OW-1:0] right_s2;
	logic                cross_s2;

	logic                 s_accept;
	logic                 advance;
	lfpd_pkg::line_cfg_t  line_cfg;
	lfpd_pkg::line_res_t  line_res;
	logic signed [OW-1:0] gap_term;
	logic signed [OW-1:0] left_drive;
	logic signed [OW-1:0] right_drive;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_p_q     <= GW'(lfpd_pkg::LINE_P_RST);
			line_d_q     <= GW'(lfpd_pkg::LINE_D_RST);
			gap_p_q      <= GW'(lfpd_pkg::GAP_P_RST);
			gap_d_q      <= GW'(lfpd_pkg::GAP_D_RST);
			target_gap_q <= GAP_BITS'(lfpd_pkg::TARGET_GAP_RST);
			far_gap_q    <= GAP_BITS'(lfpd_pkg::FAR_GAP_RST);
			cruise_q     <= DW'(lfpd_pkg::CRUISE_RST);
			gap_limit_q  <= DW'(lfpd_pkg::GAP_LIMIT_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (lfpd_pkg::cfg_idx_t'(cfg_index))
				lfpd_pkg::CFG_LINE_GAIN_P:   line_p_q     <= cfg_data[GW-1:0];
				lfpd_pkg::CFG_LINE_GAIN_D:   line_d_q     <= cfg_data[GW-1:0];
				lfpd_pkg::CFG_GAP_GAIN_P:    gap_p_q      <= cfg_data[GW-1:0];
				lfpd_pkg::CFG_GAP_GAIN_D:    gap_d_q      <= cfg_data[GW-1:0];
				lfpd_pkg::CFG_TARGET_GAP:    target_gap_q <= cfg_data;
				lfpd_pkg::CFG_FAR_GAP:       far_gap_q    <= cfg_data;
				lfpd_pkg::CFG_CRUISE_DRIVE:  cruise_q     <= cfg_data[DW-1:0];
				lfpd_pkg::CFG_GAP_OUT_LIMIT: gap_limit_q  <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			line_bits_s1 <= s_tdata[LW-1:0];
			gap_s1       <= s_tdata[LW+GAP_BITS-1:LW];
			step_s1      <= s_tdata[LW+GAP_BITS+PW-1:LW+GAP_BITS];
		end
	end

	assign line_cfg.gain_p = line_p_q;
	assign line_cfg.gain_d = line_d_q;

	lfpd_line_unit u_line (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.line_bits      (line_bits_s1),
		.travel_step_mm (step_s1),
		.cfg            (line_cfg),
		.res            (line_res)
	);

	lfpd_gap_unit #(
		.GAP_BITS (GAP_BITS)
	) u_gap (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.gap_distance (gap_s1),
		.target_gap   (target_gap_q),
		.gain_p       (gap_p_q),
		.gain_d       (gap_d_q),
		.limit        (gap_limit_q),
		.gap_term     (gap_term)
	);

	lfpd_mixer #(
		.GAP_BITS    (GAP_BITS),
		.DRIVE_LIMIT (DRIVE_LIMIT)
	) u_mixer (
		.gap_distance (gap_s1),
		.far_gap      (far_gap_q),
		.cruise_drive (cruise_q),
		.gap_term     (gap_term),
		.steer        (line_res.steer),
		.left_drive   (left_drive),
		.right_drive  (right_drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2  <= left_drive;
			right_s2 <= right_drive;
			cross_s2 <= line_res.crossing;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(lfpd_pkg::M_DATA_W-2*OW-1){1'b0}}, cross_s2, right_s2, left_s2};

`ifndef NO_ASSERTIONS
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[7:0]) <= $signed(DRIVE_LIMIT)
			&& $signed(m_tdata[7:0]) >= -$signed(DRIVE_LIMIT)))
		else $error("left drive out of range");
	a_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:8]) <= $signed(DRIVE_LIMIT)
			&& $signed(m_tdata[15:8]) >= -$signed(DRIVE_LIMIT)))
		else $error("right drive out of range");
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> valid_s1)
		else $error("accepted transaction lost at input register");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(gap_s1) && $stable(line_bits_s1)))
		else $error("input register changed while stalled");
`endif

endmodule
`default_nettype wire
